// ===== hdl/prim_minimum_spanning_tree_assert.svh =====
// Assertion macros for the spanning tree block.
// No dependencies.
`ifndef PRIM_MINIMUM_SPANNING_TREE_ASSERT_SVH
`define PRIM_MINIMUM_SPANNING_TREE_ASSERT_SVH
`define MST_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MST_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== hdl/mst_pkg.sv =====
// Package for the spanning tree block: payload types, modes, states.
// No dependencies.
package mst_pkg;
  localparam int VID_W = 6;
  localparam int WT_W = 16;
  localparam int TOT_W = 22;
  localparam logic [TOT_W-1:0] TOTAL_MAX = '1;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0, MODE_CLEAR = 2'd1, MODE_RUN = 2'd2, MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_EDGE = 2'd0, ST_UNREACH = 2'd1, ST_SINGLE = 2'd2, ST_RSVD = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_INIT, S_SCAN, S_PICK, S_UPD
  } state_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [VID_W-1:0] row;
    logic [VID_W-1:0] column;
    logic [WT_W-1:0]  weight;
  } in_req_t;

  typedef struct packed {
    logic [VID_W-1:0] from_vertex;
    logic [VID_W-1:0] to_vertex;
    logic [WT_W-1:0]  edge_weight;
    logic [TOT_W-1:0] total_weight;
    logic [1:0]       status;
    logic             last;
  } out_res_t;

  // control from sequencer to a cell
  typedef struct packed {
    logic init;
    logic upd;
    logic pick_en;
  } cell_ctl_t;
endpackage

// ===== hdl/mst_cell.sv =====
// One vertex cell: holds cost, neighbour and tree flag, hands the running
// minimum to the next cell through a register each cycle. Depends on mst_pkg.
module mst_cell import mst_pkg::*; #(
  parameter int IDX = 1,
  parameter int VW = 6,
  parameter int WB = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cell_ctl_t     ctl,
  input  logic          active,
  input  logic [WB-1:0] mat_w,
  input  logic          mat_valid,
  input  logic [VW-1:0] src_v,
  input  logic [VW-1:0] pick_v,
  input  logic [WB-1:0] min_in,
  input  logic [VW-1:0] idx_in,
  input  logic          fnd_in,
  input  logic [VW-1:0] nb_in,
  output logic [WB-1:0] min_out,
  output logic [VW-1:0] idx_out,
  output logic          fnd_out,
  output logic [VW-1:0] nb_out
);
  logic [WB-1:0] cost_r;
  logic [VW-1:0] nb_r;
  logic          tree_r;
  logic          cand;
  logic [WB-1:0] min_r;
  logic [VW-1:0] idx_r;
  logic          fnd_r;
  logic [VW-1:0] nbc_r;
  localparam logic [VW-1:0] MYIDX = VW'(IDX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tree_r <= 1'b0;
    end else if (ctl.init) begin
      tree_r <= 1'b0;
    end else if (ctl.pick_en && pick_v == MYIDX) begin
      tree_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mat_valid && ctl.init) begin
      cost_r <= mat_w;
      nb_r   <= '0;
    end else if (mat_valid && ctl.upd && !tree_r && mat_w < cost_r) begin
      cost_r <= mat_w;
      nb_r   <= src_v;
    end
  end

  assign cand = active && !tree_r && cost_r < min_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= '1;
      idx_r <= '0;
      fnd_r <= 1'b0;
      nbc_r <= '0;
    end else begin
      min_r <= cand ? cost_r : min_in;
      idx_r <= cand ? MYIDX : idx_in;
      fnd_r <= cand | fnd_in;
      nbc_r <= cand ? nb_r : nb_in;
    end
  end

  assign min_out = min_r;
  assign idx_out = idx_r;
  assign fnd_out = fnd_r;
  assign nb_out  = nbc_r;
endmodule

// ===== hdl/mst_seq.sv =====
// Sequencer: matrix memory, clearing sweep, row streaming and result build.
// Depends on mst_pkg.
module mst_seq import mst_pkg::*; #(
  parameter int NV = 64,
  parameter int WB = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  in_req_t       req,
  input  logic [6:0]    vcount,
  output logic          busy,
  output cell_ctl_t     ctl,
  output logic [WB-1:0] mat_w,
  output logic [5:0]    mat_col,
  output logic          mat_valid,
  output logic [5:0]    src_v,
  output logic [5:0]    pick_v,
  output logic [6:0]    nuse,
  input  logic [WB-1:0] min_w,
  input  logic [5:0]    min_idx,
  input  logic          min_fnd,
  input  logic [5:0]    min_nb,
  output logic          out_valid,
  output out_res_t      out_res
);
  localparam int AW = 12;
  localparam logic [WB-1:0] NOEDGE = '1;
  logic [WB-1:0] mem [0:4095];
  state_t state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [6:0] col_r, col_nxt;
  logic [5:0] row_r, row_nxt;
  logic [6:0] round_r, round_nxt;
  logic [TOT_W-1:0] tot_r, tot_nxt;
  logic rd_en, rd_v_r;
  logic [AW-1:0] rd_a;
  logic [5:0] rd_c_r;
  logic wr_en;
  logic [AW-1:0] wr_a;
  logic [WB-1:0] wr_d;
  logic [WB-1:0] rd_d_r;
  logic [TOT_W:0] sum;
  cell_ctl_t ctl_nxt;

  always_comb begin
    if (vcount == 7'd0) nuse = 7'd1;
    else if (vcount > 7'(NV)) nuse = 7'(NV);
    else nuse = vcount;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_a] <= wr_d;
    if (rd_en) rd_d_r <= mem[rd_a];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; clr_r <= '0; col_r <= '0; row_r <= '0;
      round_r <= '0; tot_r <= '0; rd_v_r <= 1'b0; ctl <= '0;
    end else begin
      state_r <= state_nxt; clr_r <= clr_nxt; col_r <= col_nxt;
      row_r <= row_nxt; round_r <= round_nxt; tot_r <= tot_nxt;
      rd_v_r <= rd_en; ctl <= ctl_nxt;
    end
  end
  always_ff @(posedge clk) rd_c_r <= col_r[5:0];

  assign mat_w = rd_d_r;
  assign mat_col = rd_c_r;
  assign mat_valid = rd_v_r;
  assign src_v = row_r;
  assign pick_v = min_idx;
  assign busy = state_r != S_IDLE;
  assign sum = {1'b0, tot_r} + (TOT_W+1)'(min_w);

  always_comb begin
    state_nxt = state_r; clr_nxt = clr_r; col_nxt = col_r; row_nxt = row_r;
    round_nxt = round_r; tot_nxt = tot_r;
    rd_en = 1'b0; rd_a = {row_r, col_r[5:0]};
    wr_en = 1'b0; wr_a = {req.row, req.column}; wr_d = req.weight;
    ctl_nxt = '0; ctl_nxt.init = ctl.init; ctl_nxt.upd = ctl.upd;
    out_valid = 1'b0; out_res = '0;
    case (state_r)
      S_CLEAR: begin
        wr_en = 1'b1; wr_a = clr_r; wr_d = NOEDGE; clr_nxt = clr_r + 1'b1;
        if (&clr_r) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        ctl_nxt = '0;
        if (start) begin
          case (mode_t'(req.mode))
            MODE_WRITE: wr_en = 1'b1;
            MODE_CLEAR: begin clr_nxt = '0; state_nxt = S_CLEAR; end
            MODE_RUN: begin
              tot_nxt = '0;
              if (nuse == 7'd1) begin
                out_valid = 1'b1; out_res.status = ST_SINGLE; out_res.last = 1'b1;
              end else begin
                row_nxt = '0; col_nxt = '0; round_nxt = 7'd1;
                ctl_nxt.init = 1'b1; state_nxt = S_INIT;
              end
            end
            default: ;
          endcase
        end
      end
      S_INIT, S_UPD: begin
        // stream row cells into the chain, one per cycle
        if (col_r < 7'(NV)) begin
          rd_en = 1'b1; col_nxt = col_r + 1'b1;
        end else if (!rd_v_r) begin
          ctl_nxt.init = 1'b0; ctl_nxt.upd = 1'b0; state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        if (!min_fnd) begin
          out_valid = 1'b1; out_res.status = ST_UNREACH; out_res.last = 1'b1;
          out_res.total_weight = tot_r; state_nxt = S_IDLE;
        end else begin
          tot_nxt = sum[TOT_W] ? TOTAL_MAX : sum[TOT_W-1:0];
          out_valid = 1'b1; out_res.status = ST_EDGE;
          out_res.from_vertex = min_nb; out_res.to_vertex = min_idx;
          out_res.edge_weight = 16'(min_w); out_res.total_weight = tot_nxt;
          out_res.last = round_r == nuse - 7'd1;
          ctl_nxt.pick_en = 1'b1;
          if (out_res.last) state_nxt = S_IDLE;
          else begin
            round_nxt = round_r + 1'b1; row_nxt = min_idx; col_nxt = '0;
            ctl_nxt.upd = 1'b1; state_nxt = S_UPD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

// ===== hdl/prim_minimum_spanning_tree.sv =====
// Top level of the Prim spanning tree block: sequencer and a row of vertex
// cells. Depends on mst_pkg, mst_seq, mst_cell and the assertion header.
//  channel | handshake          | payload
//  in      | start / busy       | in_req (in_req_t)
//  out     | out_valid strobe   | out_res (out_res_t)
//  cfg     | cfg_valid/cfg_ready| cfg_vertex_count
// Reset sweeps the matrix memory, one cell a cycle; busy stays high
// meanwhile. Write and unused mode leave busy low; clear repeats the sweep.
// A single-vertex run answers in its accept cycle; a run of n vertices keeps
// busy high until its last edge or an unreachable vertex ends it: each round
// streams one matrix row through the cell row from the memory read port while
// the minimum moves one cell per cycle. Receiver cannot stall.
`include "prim_minimum_spanning_tree_assert.svh"
module prim_minimum_spanning_tree import mst_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int WEIGHT_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_req_t    in_req,
  output logic       out_valid,
  output out_res_t   out_res,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_vertex_count
);
  localparam int NV = MAX_VERTICES;
  logic [6:0] vcount_r, nuse;
  cell_ctl_t ctl;
  logic [WEIGHT_BITS-1:0] mat_w;
  logic [5:0] mat_col, src_v, pick_v;
  logic mat_valid;
  logic [WEIGHT_BITS-1:0] mins [0:NV];
  logic [5:0] idxs [0:NV];
  logic fnds [0:NV];
  logic [5:0] nbs [0:NV];
  in_req_t req_m;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) vcount_r <= 7'd1;
    else if (cfg_valid && cfg_ready) vcount_r <= cfg_vertex_count;
  end

  always_comb begin
    req_m = in_req;
    req_m.weight = in_req.weight & 16'({WEIGHT_BITS{1'b1}});
  end

  mst_seq #(.NV(NV), .WB(WEIGHT_BITS)) u_seq (
    .clk, .rst_n, .start, .req(req_m), .vcount(vcount_r), .busy, .ctl,
    .mat_w, .mat_col, .mat_valid, .src_v, .pick_v, .nuse,
    .min_w(mins[NV]), .min_idx(idxs[NV]), .min_fnd(fnds[NV]),
    .min_nb(nbs[NV]), .out_valid, .out_res
  );

  assign mins[0] = '1;
  assign idxs[0] = '0;
  assign fnds[0] = 1'b0;
  assign nbs[0] = '0;
  assign mins[1] = mins[0];
  assign idxs[1] = idxs[0];
  assign fnds[1] = fnds[0];
  assign nbs[1] = nbs[0];

  for (genvar g = 1; g < NV; g++) begin : g_cell
    mst_cell #(.IDX(g), .VW(6), .WB(WEIGHT_BITS)) u_cell (
      .clk, .rst_n, .ctl, .active(7'(g) < nuse), .mat_w,
      .mat_valid(mat_valid && mat_col == 6'(g)), .src_v, .pick_v,
      .min_in(mins[g]), .idx_in(idxs[g]), .fnd_in(fnds[g]), .nb_in(nbs[g]),
      .min_out(mins[g+1]), .idx_out(idxs[g+1]), .fnd_out(fnds[g+1]),
      .nb_out(nbs[g+1])
    );
  end

  `MST_ASSERT_IMPL(a_strobe_busy, clk, rst_n, out_valid && !out_res.last, busy)
  `MST_ASSERT_IMPL(a_edge_weight, clk, rst_n,
    out_valid && out_res.status == ST_EDGE, out_res.edge_weight != 16'hFFFF)
  `MST_ASSERT_NEXT(a_last_idle, clk, rst_n, out_valid && out_res.last, !busy)
endmodule
